// ===== rtl/anuf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// anuf_pkg
// Shared constants for the Annex B NAL unit filter.
// ----------------------------------------------------------------------------
package anuf_pkg;

    // parse phase codes
    localparam logic [1:0] PH_SEARCH = 2'd0;   // before the first start code
    localparam logic [1:0] PH_FIRST  = 2'd1;   // next byte is the unit header
    localparam logic [1:0] PH_UNIT   = 2'd2;   // inside a unit

    localparam int unsigned BURST_MAX   = 5;   // most result bytes per request
    localparam int unsigned MASK_W      = 32;
    localparam logic [2:0]  BURST_MAX_C = 3'd5;

    localparam logic [4:0]  NAL_TYPE_BITS  = 5'h1f;
    localparam logic [31:0] DROP_MASK_RST  = 32'h0000_0041;  // types 0 and 6 (sei)

    typedef logic [7:0] byte_t;

endpackage : anuf_pkg
`default_nettype wire

// ===== rtl/annexb_nal_unit_filter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// annexb_nal_unit_filter_core
// Strips H.264 Annex B packets down to the kept NAL units, each re-emitted
// behind a four byte start code.
// ----------------------------------------------------------------------------
// channel   dir  signals                          request carries
// s         in   s_tvalid s_tready s_tdata s_tlast  in_byte, packet_last
// m         out  m_tvalid m_tready m_tdata m_tuser  out_byte, run_last,
//                m_tlast                            byte_valid, packet_end
// cfg       in   cfg_we cfg_wdata                   drop_type_mask
//
// one input request per cycle, while m does not stall, when it produces at most
// one result byte; a request producing n result bytes occupies the output burst
// buffer until all n have left, and the next request is taken in the cycle its last byte leaves.
// reset clears the parser and the burst buffer; drop_type_mask resets to 0x41.
// a stall on m holds the burst buffer and blocks s while it holds any byte.
// ----------------------------------------------------------------------------
module annexb_nal_unit_filter_core
    import anuf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,   // packet_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [8] run_last, [15:9] zero
    output logic             m_tuser,   // byte_valid
    output logic             m_tlast    // packet_end
);

    logic [MASK_W-1:0] mask_reg;

    logic [1:0] phase_reg, phase_next;
    logic [1:0] zrun_reg, zrun_next;
    logic       keep_reg, keep_next;
    logic [1:0] pend_reg, pend_next;

    byte_t      data_reg [BURST_MAX];
    logic [2:0] cnt_reg;
    logic       marker_reg;
    logic       end_reg;

    byte_t      lst [BURST_MAX];
    logic [2:0] n_res;
    logic       marker_res;

    logic       s_acc, m_acc;
    byte_t      b;
    logic       hdr_keep;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;
    assign b     = s_tdata;

    assign s_tready = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && m_tready);
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = {7'd0, (cnt_reg == 3'd1), data_reg[0]};
    assign m_tuser  = !marker_reg;
    assign m_tlast  = end_reg && (cnt_reg == 3'd1);

    assign hdr_keep = !mask_reg[b[4:0] & NAL_TYPE_BITS];

    // parser step and result burst for one request
    always_comb
    begin
        phase_next = phase_reg;
        zrun_next  = zrun_reg;
        keep_next  = keep_reg;
        pend_next  = pend_reg;
        n_res      = 3'd0;
        marker_res = 1'b0;
        for (int i = 0; i < BURST_MAX; i++)
        begin
            lst[i] = 8'd0;
        end

        case (phase_reg)
            PH_SEARCH:
            begin
                if (b == 8'd0)
                begin
                    if (zrun_reg != 2'd3)
                        zrun_next = zrun_reg + 2'd1;
                end
                else if (b == 8'd1 && zrun_reg >= 2'd2)
                begin
                    phase_next = PH_FIRST;
                    zrun_next  = 2'd0;
                end
                else
                begin
                    zrun_next = 2'd0;
                end
            end
            PH_FIRST:
            begin
                phase_next = PH_UNIT;
                pend_next  = 2'd0;
                if (b == 8'd0)
                begin
                    keep_next = 1'b0;
                    zrun_next = 2'd1;
                end
                else
                begin
                    keep_next = hdr_keep;
                    zrun_next = 2'd0;
                    if (hdr_keep)
                    begin
                        lst[3] = 8'd1;
                        lst[4] = b;
                        n_res  = BURST_MAX_C;
                    end
                end
            end
            PH_UNIT:
            begin
                if (b == 8'd0)
                begin
                    if (zrun_reg != 2'd3)
                        zrun_next = zrun_reg + 2'd1;
                    if (keep_reg)
                    begin
                        // only three zeros can belong to a start code
                        if (pend_reg == 2'd3)
                            n_res = 3'd1;
                        else
                            pend_next = pend_reg + 2'd1;
                    end
                end
                else if (b == 8'd1 && zrun_reg >= 2'd2)
                begin
                    phase_next = PH_FIRST;
                    zrun_next  = 2'd0;
                    keep_next  = 1'b0;
                    pend_next  = 2'd0;
                end
                else
                begin
                    if (keep_reg)
                    begin
                        for (int i = 0; i < BURST_MAX; i++)
                        begin
                            if (i == int'(pend_reg))
                                lst[i] = b;
                        end
                        n_res = {1'b0, pend_reg} + 3'd1;
                    end
                    pend_next = 2'd0;
                    zrun_next = 2'd0;
                end
            end
            default:
            begin
                phase_next = PH_SEARCH;
            end
        endcase

        if (s_tlast)
        begin
            // last unit runs to packet end, flush held zeros
            if (phase_next == PH_UNIT && keep_next)
                n_res = n_res + {1'b0, pend_next};
            phase_next = PH_SEARCH;
            zrun_next  = 2'd0;
            keep_next  = 1'b0;
            pend_next  = 2'd0;
            if (n_res == 3'd0)
            begin
                n_res      = 3'd1;
                marker_res = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= DROP_MASK_RST;
            phase_reg <= PH_SEARCH;
            zrun_reg  <= 2'd0;
            keep_reg  <= 1'b0;
            pend_reg  <= 2'd0;
        end
        else
        begin
            if (cfg_we)
                mask_reg <= cfg_wdata;
            if (s_acc)
            begin
                phase_reg <= phase_next;
                zrun_reg  <= zrun_next;
                keep_reg  <= keep_next;
                pend_reg  <= pend_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 3'd0;
            marker_reg <= 1'b0;
            end_reg    <= 1'b0;
        end
        else if (s_acc)
        begin
            cnt_reg    <= n_res;
            marker_reg <= marker_res;
            end_reg    <= s_tlast;
        end
        else if (m_acc)
        begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    // burst payload shifts toward slot 0 as bytes leave
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            for (int i = 0; i < BURST_MAX; i++)
            begin
                data_reg[i] <= lst[i];
            end
        end
        else if (m_acc)
        begin
            for (int i = 0; i < BURST_MAX - 1; i++)
            begin
                data_reg[i] <= data_reg[i + 1];
            end
        end
    end

    a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= BURST_MAX_C)
        else $error("burst count out of range");

    a_marker_alone : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && marker_reg) |-> (cnt_reg == 3'd1 && end_reg))
        else $error("packet end marker not alone");

    a_accept_fills : assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && s_tlast) |=> (m_tvalid && end_reg))
        else $error("packet end produced no result");

    a_pend_in_unit : assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != 2'd0) |-> (phase_reg == PH_UNIT && keep_reg))
        else $error("held zeros outside a kept unit");

endmodule : annexb_nal_unit_filter_core
`default_nettype wire
